// File: rtl/ems_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and character classes for the export marker scanner
// no dependencies

package ems_pkg;

    localparam int DEF_RAW_DELIM_SLOTS = 17;
    localparam int DEF_MAX_IDENT_LEN   = 255;

    // result kinds
    localparam logic [1:0] KIND_IDENT    = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_READ       = 3'd1;
    localparam logic [2:0] ERR_EARLY_END  = 3'd2;
    localparam logic [2:0] ERR_BAD_START  = 3'd3;
    localparam logic [2:0] ERR_DOUBLE_US  = 3'd4;
    localparam logic [2:0] ERR_NOT_FUNC   = 3'd5;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd6;

    // characters
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_UPPER_R = 8'h52;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_USCORE  = 8'h5f;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_BLANK   = 8'h20;

    // rest of the namespace word after its leading 'd'
    localparam logic [7:0] WORD_REST [4] = '{8'h6f, 8'h61, 8'h72, 8'h72};
    // rest of "exported" after the leading 'e'
    localparam logic [7:0] TAIL_REST [7] = '{8'h78, 8'h70, 8'h6f, 8'h72,
                                             8'h74, 8'h65, 8'h64};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
        logic       read_failed;
    } item_t;

    typedef struct packed {
        logic       has;
        logic [1:0] kind;
        logic [7:0] ident_byte;
        logic [2:0] error_code;
    } res_t;

    function automatic logic is_start_char(input logic [7:0] c);
        return (c == CH_DOLLAR) || (c >= 8'h41 && c <= 8'h5a) || (c == CH_USCORE) ||
               (c >= 8'h61 && c <= 8'h7a) || c[7];
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_start_char(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c <= CH_BLANK;
    endfunction

endpackage

// File: rtl/ems_scan.sv
`timescale 1ns / 1ps
// scanner state, raw delimiter store and the per-byte transition logic
// depends on ems_pkg

module ems_scan #(
    parameter int RAW_DELIM_SLOTS = ems_pkg::DEF_RAW_DELIM_SLOTS,
    parameter int MAX_IDENT_LEN   = ems_pkg::DEF_MAX_IDENT_LEN
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  ems_pkg::item_t item,
    output ems_pkg::res_t  res
);

    localparam int DLEN_W = $clog2(RAW_DELIM_SLOTS + 1);
    localparam int DIDX_W = $clog2(RAW_DELIM_SLOTS);
    localparam int MPOS_W = (DLEN_W > 3) ? DLEN_W : 3;
    localparam int LEN_W  = $clog2(MAX_IDENT_LEN + 1);

    localparam logic [3:0] M_TOP        = 4'd0;
    localparam logic [3:0] M_R_SEEN     = 4'd1;
    localparam logic [3:0] M_STR        = 4'd2;
    localparam logic [3:0] M_STR_ESC    = 4'd3;
    localparam logic [3:0] M_RAW_DELIM  = 4'd4;
    localparam logic [3:0] M_RAW_BODY   = 4'd5;
    localparam logic [3:0] M_RAW_MATCH  = 4'd6;
    localparam logic [3:0] M_WORD       = 4'd7;
    localparam logic [3:0] M_COLON1     = 4'd8;
    localparam logic [3:0] M_COLON2     = 4'd9;
    localparam logic [3:0] M_WANT_E     = 4'd10;
    localparam logic [3:0] M_TAIL       = 4'd11;
    localparam logic [3:0] M_NAME_START = 4'd12;
    localparam logic [3:0] M_NAME       = 4'd13;
    localparam logic [3:0] M_PAREN      = 4'd14;

    logic [3:0]        mode_reg, mode_next;
    logic              prev_ident_reg, prev_ident_next;
    logic [MPOS_W-1:0] match_pos_reg, match_pos_next;
    logic [DLEN_W-1:0] raw_len_reg, raw_len_next;
    logic [LEN_W-1:0]  ident_len_reg, ident_len_next;
    logic              last_us_reg, last_us_next;
    logic              dbl_us_reg, dbl_us_next;

    logic [7:0]        delim_mem [RAW_DELIM_SLOTS];
    logic              delim_we;
    logic [7:0]        delim_wdata;
    logic [7:0]        delim_rdata;

    logic [7:0]        b;
    logic              do_top;
    logic              do_body;
    logic              top_prev;
    logic              fin;
    logic [DLEN_W-1:0] raw_len_eff;
    logic [MPOS_W-1:0] match_inc;

    assign b           = item.data_byte;
    assign delim_rdata = delim_mem[match_pos_reg[DIDX_W-1:0]];
    assign match_inc   = match_pos_reg + MPOS_W'(1);

    always_comb
    begin
        mode_next       = mode_reg;
        prev_ident_next = prev_ident_reg;
        match_pos_next  = match_pos_reg;
        raw_len_next    = raw_len_reg;
        ident_len_next  = ident_len_reg;
        last_us_next    = last_us_reg;
        dbl_us_next     = dbl_us_reg;
        delim_we        = 1'b0;
        delim_wdata     = (b == ems_pkg::CH_LPAREN) ? ems_pkg::CH_QUOTE : b;
        raw_len_eff     = raw_len_reg;
        res             = '0;
        do_top          = 1'b0;
        do_body         = 1'b0;
        top_prev        = prev_ident_reg;
        fin             = 1'b0;

        if (item.end_of_input)
        begin
            fin          = 1'b1;
            res.has      = 1'b1;
            res.kind     = ems_pkg::KIND_ERROR;
            if (mode_reg == M_NAME_START || mode_reg == M_NAME)
                res.error_code = item.read_failed ? ems_pkg::ERR_READ
                                                  : ems_pkg::ERR_EARLY_END;
            else if (mode_reg == M_PAREN)
                res.error_code = ems_pkg::ERR_NOT_FUNC;
            else if (item.read_failed)
                res.error_code = ems_pkg::ERR_READ;
            else
            begin
                res.kind       = ems_pkg::KIND_END;
                res.error_code = ems_pkg::ERR_NONE;
            end
        end
        else
        begin
            case (mode_reg)
                M_TOP:
                    do_top = 1'b1;
                M_R_SEEN:
                    if (b == ems_pkg::CH_QUOTE)
                    begin
                        mode_next    = M_RAW_DELIM;
                        raw_len_next = '0;
                    end
                    else
                    begin
                        // the R counts as an identifier character for this byte
                        do_top          = 1'b1;
                        top_prev        = 1'b1;
                        prev_ident_next = 1'b1;
                    end
                M_STR:
                    if (b == ems_pkg::CH_QUOTE)
                    begin
                        mode_next       = M_TOP;
                        prev_ident_next = 1'b0;
                    end
                    else if (b == ems_pkg::CH_BSLASH)
                        mode_next = M_STR_ESC;
                M_STR_ESC:
                    mode_next = M_STR;
                M_RAW_DELIM:
                begin
                    if (raw_len_reg < DLEN_W'(RAW_DELIM_SLOTS))
                    begin
                        delim_we    = 1'b1;
                        raw_len_eff = raw_len_reg + DLEN_W'(1);
                    end
                    raw_len_next = raw_len_eff;
                    if (b == ems_pkg::CH_LPAREN || raw_len_eff >= DLEN_W'(RAW_DELIM_SLOTS))
                        mode_next = M_RAW_BODY;
                end
                M_RAW_BODY:
                    do_body = 1'b1;
                M_RAW_MATCH:
                    if (match_pos_reg < MPOS_W'(raw_len_reg) && b == delim_rdata)
                    begin
                        match_pos_next = match_inc;
                        if (match_inc >= MPOS_W'(raw_len_reg))
                        begin
                            mode_next       = M_TOP;
                            prev_ident_next = 1'b0;
                            match_pos_next  = '0;
                        end
                    end
                    else
                        do_body = 1'b1;
                M_WORD:
                    if (match_pos_reg < MPOS_W'(4) &&
                        b == ems_pkg::WORD_REST[match_pos_reg[1:0]])
                    begin
                        match_pos_next = match_inc;
                        if (match_inc >= MPOS_W'(4))
                            mode_next = M_COLON1;
                    end
                    else
                        do_top = 1'b1;
                M_COLON1, M_COLON2, M_WANT_E:
                    if (!ems_pkg::is_blank(b))
                    begin
                        if (mode_reg == M_COLON1 && b == ems_pkg::CH_COLON)
                            mode_next = M_COLON2;
                        else if (mode_reg == M_COLON2 && b == ems_pkg::CH_COLON)
                            mode_next = M_WANT_E;
                        else if (mode_reg == M_WANT_E && b == ems_pkg::CH_LOWER_E)
                        begin
                            mode_next      = M_TAIL;
                            match_pos_next = '0;
                        end
                        else
                            mode_next = M_TOP;
                    end
                M_TAIL:
                    if (match_pos_reg < MPOS_W'(7) &&
                        b == ems_pkg::TAIL_REST[match_pos_reg[2:0]])
                    begin
                        match_pos_next = match_inc;
                        if (match_inc >= MPOS_W'(7))
                        begin
                            mode_next      = M_NAME_START;
                            match_pos_next = '0;
                        end
                    end
                    else
                        do_top = 1'b1;
                M_NAME_START:
                    if (!ems_pkg::is_blank(b))
                    begin
                        if (!ems_pkg::is_start_char(b))
                        begin
                            fin            = 1'b1;
                            res.has        = 1'b1;
                            res.kind       = ems_pkg::KIND_ERROR;
                            res.error_code = ems_pkg::ERR_BAD_START;
                        end
                        else
                        begin
                            ident_len_next = LEN_W'(1);
                            last_us_next   = (b == ems_pkg::CH_USCORE);
                            dbl_us_next    = 1'b0;
                            mode_next      = M_NAME;
                            res.has        = 1'b1;
                            res.kind       = ems_pkg::KIND_IDENT;
                            res.ident_byte = b;
                        end
                    end
                M_NAME:
                begin
                    res.has = 1'b1;
                    if (ems_pkg::is_name_char(b))
                    begin
                        if (ident_len_reg >= LEN_W'(MAX_IDENT_LEN))
                        begin
                            fin            = 1'b1;
                            res.kind       = ems_pkg::KIND_ERROR;
                            res.error_code = ems_pkg::ERR_TOO_LONG;
                        end
                        else
                        begin
                            dbl_us_next    = dbl_us_reg ||
                                             (last_us_reg && b == ems_pkg::CH_USCORE);
                            last_us_next   = (b == ems_pkg::CH_USCORE);
                            ident_len_next = ident_len_reg + LEN_W'(1);
                            res.kind       = ems_pkg::KIND_IDENT;
                            res.ident_byte = b;
                        end
                    end
                    else if (dbl_us_reg)
                    begin
                        fin            = 1'b1;
                        res.kind       = ems_pkg::KIND_ERROR;
                        res.error_code = ems_pkg::ERR_DOUBLE_US;
                    end
                    else if (b == ems_pkg::CH_LPAREN)
                    begin
                        fin      = 1'b1;
                        res.kind = ems_pkg::KIND_COMPLETE;
                    end
                    else if (ems_pkg::is_blank(b))
                    begin
                        res.has   = 1'b0;
                        mode_next = M_PAREN;
                    end
                    else
                    begin
                        fin            = 1'b1;
                        res.kind       = ems_pkg::KIND_ERROR;
                        res.error_code = ems_pkg::ERR_NOT_FUNC;
                    end
                end
                M_PAREN:
                    if (!ems_pkg::is_blank(b))
                    begin
                        fin     = 1'b1;
                        res.has = 1'b1;
                        if (b == ems_pkg::CH_LPAREN)
                            res.kind = ems_pkg::KIND_COMPLETE;
                        else
                        begin
                            res.kind       = ems_pkg::KIND_ERROR;
                            res.error_code = ems_pkg::ERR_NOT_FUNC;
                        end
                    end
                default:
                begin
                    // unused code: recover to top level and scan this byte there
                    match_pos_next  = '0;
                    ident_len_next  = '0;
                    last_us_next    = 1'b0;
                    dbl_us_next     = 1'b0;
                    prev_ident_next = 1'b0;
                    top_prev        = 1'b0;
                    do_top          = 1'b1;
                end
            endcase

            // top-level handling, also for bytes handed back by a broken match
            if (do_top)
            begin
                mode_next = M_TOP;
                if (b == ems_pkg::CH_QUOTE)
                    mode_next = M_STR;
                else if (b == ems_pkg::CH_UPPER_R)
                    mode_next = M_R_SEEN;
                else if (b == ems_pkg::CH_LOWER_D)
                begin
                    if (!top_prev)
                    begin
                        mode_next      = M_WORD;
                        match_pos_next = '0;
                    end
                end
                else
                    prev_ident_next = ems_pkg::is_name_char(b);
            end

            if (do_body)
            begin
                mode_next = M_RAW_BODY;
                if (b == ems_pkg::CH_RPAREN)
                begin
                    mode_next      = M_RAW_MATCH;
                    match_pos_next = '0;
                end
            end
        end

        if (fin)
        begin
            mode_next       = M_TOP;
            prev_ident_next = 1'b0;
            match_pos_next  = '0;
            ident_len_next  = '0;
            last_us_next    = 1'b0;
            dbl_us_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_TOP;
            prev_ident_reg <= 1'b0;
            match_pos_reg  <= '0;
            raw_len_reg    <= '0;
            ident_len_reg  <= '0;
            last_us_reg    <= 1'b0;
            dbl_us_reg     <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            prev_ident_reg <= prev_ident_next;
            match_pos_reg  <= match_pos_next;
            raw_len_reg    <= raw_len_next;
            ident_len_reg  <= ident_len_next;
            last_us_reg    <= last_us_next;
            dbl_us_reg     <= dbl_us_next;
        end
    end

    // delimiter store has no reset, entries are written before they are compared
    always_ff @(posedge clk)
    begin
        if (fire && delim_we)
            delim_mem[raw_len_reg[DIDX_W-1:0]] <= delim_wdata;
    end

    a_finish_to_top: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.has && res.kind != ems_pkg::KIND_IDENT
        |=> mode_reg == M_TOP && ident_len_reg == '0 && match_pos_reg == '0)
        else $error("scanner did not return to top level after a final result");

    a_ident_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ident_len_reg <= LEN_W'(MAX_IDENT_LEN))
        else $error("identifier length beyond limit");

    a_raw_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        raw_len_reg <= DLEN_W'(RAW_DELIM_SLOTS))
        else $error("raw delimiter length beyond store depth");

    a_raw_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_RAW_MATCH |-> match_pos_reg < MPOS_W'(raw_len_reg))
        else $error("raw close match position past delimiter length");

endmodule

// File: rtl/export_marker_scanner_core.sv
`timescale 1ns / 1ps
// Export marker scanner, top level: input register, scanner, result register.
// Takes the source one byte per transaction on the input channel and emits
// identifier bytes, completion, end and error results on the output channel.
// depends on ems_pkg and ems_scan
//
// Input channel (in_valid / in_stall): one transaction per byte, or an end
// marker with end_of_input set and read_failed telling a read error apart.
// Output channel (out_valid / out_stall): zero or one result per input
// transaction, in order: kind, ident_byte, error_code.
// Path: a byte accepted into the input register is scanned from there; its
// result, if any, is loaded into the output register as the byte moves on and
// shows on the output ports from then on.
// Throughput: one byte per cycle while no result is held by out_stall; the scanner
// state holds one short transition per byte, so such bytes stream without gaps.
// Stall: a held result stays stable while out_stall is high; the byte in the
// input register then waits only if it produces a result of its own, and
// in_stall rises once the input register is full and cannot move on.
// Reset: asynchronous, active low; both registers empty, scanner at top level.

module export_marker_scanner_core #(
    parameter int RAW_DELIM_SLOTS = ems_pkg::DEF_RAW_DELIM_SLOTS,
    parameter int MAX_IDENT_LEN   = ems_pkg::DEF_MAX_IDENT_LEN
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    input  logic       read_failed,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] ident_byte,
    output logic [2:0] error_code
);

    logic           s1_valid_reg, s1_valid_next;
    ems_pkg::item_t s1_item_reg;
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     kind_reg;
    logic [7:0]     ident_reg;
    logic [2:0]     err_reg;

    ems_pkg::res_t  res;
    logic           out_free;
    logic           s1_adv;
    logic           in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!res.has || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    ems_scan #(
        .RAW_DELIM_SLOTS (RAW_DELIM_SLOTS),
        .MAX_IDENT_LEN   (MAX_IDENT_LEN)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_adv),
        .item  (s1_item_reg),
        .res   (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = s1_adv && res.has;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.data_byte    <= data_byte;
            s1_item_reg.end_of_input <= end_of_input;
            s1_item_reg.read_failed  <= read_failed;
        end
        if (out_free && s1_adv && res.has)
        begin
            kind_reg  <= res.kind;
            ident_reg <= res.ident_byte;
            err_reg   <= res.error_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign ident_byte = ident_reg;
    assign error_code = err_reg;

    a_ident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != ems_pkg::KIND_IDENT |-> ident_reg == 8'h00)
        else $error("identifier byte set on a non-identifier result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != ems_pkg::KIND_ERROR |-> err_reg == ems_pkg::ERR_NONE)
        else $error("error code set on a non-error result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule

// File: verif/export_marker_checker.sv
`timescale 1ns / 1ps
// checker for the export marker scanner: follows both channels, predicts the result
// of every accepted source byte and compares results in order; depends on ems_pkg

module export_marker_checker #(
    parameter int DELIM_SLOTS = ems_pkg::DEF_RAW_DELIM_SLOTS,
    parameter int NAME_LIMIT  = ems_pkg::DEF_MAX_IDENT_LEN
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    input  logic       read_failed,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] kind,
    input  logic [7:0] ident_byte,
    input  logic [2:0] error_code,
    output int         fail_count,
    output int         outstanding
);
    import ems_pkg::*;

    typedef enum logic [3:0] {
        SC_TOP, SC_AFTER_R, SC_STRING, SC_STRING_ESC, SC_RAW_OPEN, SC_RAW_TEXT,
        SC_RAW_CLOSE, SC_WORD, SC_COLON_A, SC_COLON_B, SC_WANT_E, SC_TAIL,
        SC_NAME_FIRST, SC_NAME, SC_WANT_PAREN
    } scan_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [2:0] code;
    } outcome_t;

    // namespace word after its 'd', and "exported" after its 'e'
    localparam logic [7:0] WORD_AFTER_D [4] = '{8'h6f, 8'h61, 8'h72, 8'h72};
    localparam logic [7:0] EXPORT_AFTER_E [7] = '{8'h78, 8'h70, 8'h6f, 8'h72,
                                                  8'h74, 8'h65, 8'h64};

    scan_state_t state       = SC_TOP;
    logic        after_ident = 1'b0;
    int          pos         = 0;
    logic [7:0]  delim [DELIM_SLOTS];
    int          tag_count   = 0;
    int          name_len    = 0;
    logic        last_us     = 1'b0;
    logic        saw_double  = 1'b0;
    outcome_t    pending_results [$];
    int          mismatches  = 0;

    assign fail_count = mismatches;

    function automatic logic starts_name(input logic [7:0] c);
        return c == CH_DOLLAR || c == CH_USCORE || c >= 8'h80 ||
               (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic in_name(input logic [7:0] c);
        return starts_name(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic void return_to_top();
        state       = SC_TOP;
        after_ident = 1'b0;
        pos         = 0;
        name_len    = 0;
        last_us     = 1'b0;
        saw_double  = 1'b0;
    endfunction

    function automatic void expect_result(input logic [1:0] k, input logic [7:0] c,
                                          input logic [2:0] e);
        outcome_t o;
        o.kind = k;
        o.ch   = c;
        o.code = e;
        pending_results.push_back(o);
    endfunction

    function automatic void conclude(input logic [1:0] k, input logic [2:0] e);
        return_to_top();
        expect_result(k, 8'h00, e);
    endfunction

    function automatic void take_name_byte(input logic [7:0] b);
        if (b == CH_USCORE)
        begin
            if (last_us)
                saw_double = 1'b1;
            last_us = 1'b1;
        end
        else
            last_us = 1'b0;
        name_len++;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic eoi, input logic rf);
        logic again;
        if (eoi)
        begin
            if (state == SC_NAME_FIRST || state == SC_NAME)
                conclude(KIND_ERROR, rf ? ERR_READ : ERR_EARLY_END);
            else if (state == SC_WANT_PAREN)
                conclude(KIND_ERROR, ERR_NOT_FUNC);
            else if (rf)
                conclude(KIND_ERROR, ERR_READ);
            else
                conclude(KIND_END, ERR_NONE);
            return;
        end
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (state)
                SC_TOP:
                begin
                    if (b == CH_QUOTE)
                        state = SC_STRING;
                    else if (b == CH_UPPER_R)
                        state = SC_AFTER_R;
                    else if (b == CH_LOWER_D)
                    begin
                        if (!after_ident)
                        begin
                            state = SC_WORD;
                            pos   = 0;
                        end
                    end
                    else
                        after_ident = in_name(b);
                end
                SC_AFTER_R:
                begin
                    if (b == CH_QUOTE)
                    begin
                        state     = SC_RAW_OPEN;
                        tag_count = 0;
                    end
                    else
                    begin
                        // plain R: it was an identifier character, look at this byte again
                        after_ident = 1'b1;
                        state       = SC_TOP;
                        again       = 1'b1;
                    end
                end
                SC_STRING:
                begin
                    if (b == CH_QUOTE)
                    begin
                        state       = SC_TOP;
                        after_ident = 1'b0;
                    end
                    else if (b == CH_BSLASH)
                        state = SC_STRING_ESC;
                end
                SC_STRING_ESC:
                    state = SC_STRING;
                SC_RAW_OPEN:
                begin
                    if (tag_count < DELIM_SLOTS)
                    begin
                        delim[tag_count] = (b == CH_LPAREN) ? CH_QUOTE : b;
                        tag_count++;
                    end
                    if (b == CH_LPAREN || tag_count >= DELIM_SLOTS)
                        state = SC_RAW_TEXT;
                end
                SC_RAW_TEXT:
                begin
                    if (b == CH_RPAREN)
                    begin
                        state = SC_RAW_CLOSE;
                        pos   = 0;
                    end
                end
                SC_RAW_CLOSE:
                begin
                    if (pos < tag_count && pos < DELIM_SLOTS && b == delim[pos])
                    begin
                        pos++;
                        if (pos >= tag_count)
                        begin
                            state       = SC_TOP;
                            after_ident = 1'b0;
                            pos         = 0;
                        end
                    end
                    else
                    begin
                        state = SC_RAW_TEXT;
                        again = 1'b1;
                    end
                end
                SC_WORD:
                begin
                    if (pos < 4 && b == WORD_AFTER_D[pos])
                    begin
                        pos++;
                        if (pos >= 4)
                            state = SC_COLON_A;
                    end
                    else
                    begin
                        state = SC_TOP;
                        again = 1'b1;
                    end
                end
                SC_COLON_A, SC_COLON_B, SC_WANT_E:
                begin
                    // blanks are skipped, any other wrong byte is dropped
                    if (b > CH_BLANK)
                    begin
                        if (state == SC_COLON_A && b == CH_COLON)
                            state = SC_COLON_B;
                        else if (state == SC_COLON_B && b == CH_COLON)
                            state = SC_WANT_E;
                        else if (state == SC_WANT_E && b == CH_LOWER_E)
                        begin
                            state = SC_TAIL;
                            pos   = 0;
                        end
                        else
                            state = SC_TOP;
                    end
                end
                SC_TAIL:
                begin
                    if (pos < 7 && b == EXPORT_AFTER_E[pos])
                    begin
                        pos++;
                        if (pos >= 7)
                        begin
                            state = SC_NAME_FIRST;
                            pos   = 0;
                        end
                    end
                    else
                    begin
                        state = SC_TOP;
                        again = 1'b1;
                    end
                end
                SC_NAME_FIRST:
                begin
                    if (b > CH_BLANK)
                    begin
                        if (!starts_name(b))
                            conclude(KIND_ERROR, ERR_BAD_START);
                        else
                        begin
                            name_len   = 0;
                            last_us    = 1'b0;
                            saw_double = 1'b0;
                            take_name_byte(b);
                            state = SC_NAME;
                            expect_result(KIND_IDENT, b, ERR_NONE);
                        end
                    end
                end
                SC_NAME:
                begin
                    if (in_name(b))
                    begin
                        if (name_len >= NAME_LIMIT)
                            conclude(KIND_ERROR, ERR_TOO_LONG);
                        else
                        begin
                            take_name_byte(b);
                            expect_result(KIND_IDENT, b, ERR_NONE);
                        end
                    end
                    else if (saw_double)
                        conclude(KIND_ERROR, ERR_DOUBLE_US);
                    else if (b == CH_LPAREN)
                        conclude(KIND_COMPLETE, ERR_NONE);
                    else if (b <= CH_BLANK)
                        state = SC_WANT_PAREN;
                    else
                        conclude(KIND_ERROR, ERR_NOT_FUNC);
                end
                SC_WANT_PAREN:
                begin
                    if (b == CH_LPAREN)
                        conclude(KIND_COMPLETE, ERR_NONE);
                    else if (b > CH_BLANK)
                        conclude(KIND_ERROR, ERR_NOT_FUNC);
                end
                default:
                begin
                    return_to_top();
                    again = 1'b1;
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            return_to_top();
            tag_count = 0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                scan_byte(data_byte, end_of_input, read_failed);
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $error("unexpected result: kind %0d ident_byte 0x%02h error_code %0d",
                           kind, ident_byte, error_code);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        mismatches++;
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                    end
                    if (ident_byte !== want.ch)
                    begin
                        mismatches++;
                        $error("ident_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want.ch, ident_byte);
                    end
                    if (error_code !== want.code)
                    begin
                        mismatches++;
                        $error("error_code mismatch: expected %0d, actual %0d",
                               want.code, error_code);
                    end
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// File: verif/tb_export_marker_scanner_core.sv
`timescale 1ns / 1ps
// testbench top for export_marker_scanner_core: clock, reset, source byte stimulus,
// output stall and verdict; depends on ems_pkg, the core and export_marker_checker

module tb_export_marker_scanner_core;
    import ems_pkg::*;

    localparam int IDLE_PCT     = 32;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 300;

    // namespace word of the marker, spelled as bytes
    localparam logic [7:0] NS_WORD [5] = '{8'h64, 8'h6f, 8'h61, 8'h72, 8'h72};

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic [7:0] data_byte    = 8'h00;
    logic       end_of_input = 1'b0;
    logic       read_failed  = 1'b0;
    logic       out_stall    = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] kind;
    logic [7:0] ident_byte;
    logic [2:0] error_code;

    int   fail_count;
    int   outstanding;
    int   idle_cycles = 0;
    logic steady      = 1'b0;
    logic draining    = 1'b0;
    item_t source_q [$];

    always #10 clk = ~clk;

    export_marker_scanner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .read_failed  (read_failed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .ident_byte   (ident_byte),
        .error_code   (error_code)
    );

    export_marker_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .read_failed  (read_failed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .ident_byte   (ident_byte),
        .error_code   (error_code),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // ---------------------------------------------------------------- source text

    function automatic void push_byte(input logic [7:0] b);
        item_t it;
        it.data_byte    = b;
        it.end_of_input = 1'b0;
        it.read_failed  = ($urandom_range(0, 7) == 0);
        source_q.push_back(it);
    endfunction

    function automatic void push_end(input logic rf);
        item_t it;
        it.data_byte    = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        it.read_failed  = rf;
        source_q.push_back(it);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_blanks(input int n);
        repeat (n) push_byte(8'($urandom_range(0, 32)));
    endfunction

    function automatic logic [7:0] name_byte(input logic lead);
        int sel;
        sel = $urandom_range(lead ? 1 : 0, 5);
        case (sel)
            0:       return 8'($urandom_range(8'h30, 8'h39));
            1:       return 8'($urandom_range(8'h61, 8'h7a));
            2:       return 8'($urandom_range(8'h41, 8'h5a));
            3:       return CH_USCORE;
            4:       return 8'($urandom_range(8'h80, 8'hff));
            default: return CH_DOLLAR;
        endcase
    endfunction

    // full marker with up to gap blanks at each place they may stand; cut keeps a prefix
    function automatic void push_marker(input int gap, input int cut = -1);
        logic [7:0] m [$];
        string      tail;
        tail = "exported";
        foreach (NS_WORD[i])
            m.push_back(NS_WORD[i]);
        repeat ($urandom_range(0, gap)) m.push_back(8'($urandom_range(0, 32)));
        m.push_back(CH_COLON);
        repeat ($urandom_range(0, gap)) m.push_back(8'($urandom_range(0, 32)));
        m.push_back(CH_COLON);
        repeat ($urandom_range(0, gap)) m.push_back(8'($urandom_range(0, 32)));
        for (int i = 0; i < tail.len(); i++)
            m.push_back(tail[i]);
        for (int i = 0; i < m.size() && (cut < 0 || i < cut); i++)
            push_byte(m[i]);
    endfunction

    function automatic void push_letters(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'h61 + 8'(i % 26));
    endfunction

    function automatic void load_directed();
        push_end(1'b0);
        push_end(1'b1);
        push_marker(0);
        push_text("foo(");
        // blanks everywhere, dollar and high byte in the name, blank before the paren
        push_marker(2);
        push_blanks(2);
        push_text("$Ab_9");
        push_byte(8'hff);
        push_byte(8'h00);
        push_byte(CH_LPAREN);
        // marker right after an identifier character does not count
        push_text("x");
        push_marker(0);
        push_text("f( ");
        push_marker(0);
        push_text("a__b(");
        push_text(";");
        push_marker(0);
        push_text(" 9");
        push_marker(0);
        push_text("go;");
        push_marker(1);
        push_text("go x");
        // longest legal name followed by one byte too many
        push_marker(0);
        push_letters(DEF_MAX_IDENT_LEN + 1);
        push_text("( ");
        // end while reading the name, while waiting for the paren, before any name
        push_marker(0);
        push_text("ab");
        push_end(1'b0);
        push_marker(0);
        push_text("ab");
        push_end(1'b1);
        push_marker(0);
        push_text("ab ");
        push_end(1'b0);
        push_marker(0);
        push_end(1'b0);
        // marker hidden inside a string with an escaped quote
        push_text("\"\\\" ");
        push_marker(0);
        push_text("s(\" ");
        // raw string with a near miss on the closing delimiter
        push_text("R\"xy(");
        push_marker(0);
        push_text(")x ))xy\" ");
        push_marker(0);
        push_text("r(");
        // plain R before the word, then R before a separator
        push_text("R");
        push_marker(0);
        push_text("f( R;");
        push_marker(0);
        push_text("q(");
        // delimiter that fills every slot without a paren
        push_text("R\"abcdefghijklmnopqzz)abcdefghijklmnopq ");
        push_marker(0);
        push_text("v(");
        // broken markers: inside the word, a printable at a colon, inside the tail
        push_text(" ");
        push_marker(0, 4);
        push_byte(CH_COLON);
        push_text(" ");
        push_marker(0, 5);
        push_text(":x");
        push_text(" ");
        push_marker(0, 14);
        push_text("x ");
        push_end(1'b0);
    endfunction

    function automatic void push_export();
        int len;
        if ($urandom_range(0, 9) == 0)
            push_byte(name_byte(1'b0));
        else
            push_blanks(1);
        push_marker(2);
        push_blanks($urandom_range(0, 2));
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 260) : $urandom_range(1, 10);
        push_byte(($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : name_byte(1'b1));
        for (int i = 1; i < len; i++)
            push_byte(name_byte(1'b0));
        case ($urandom_range(0, 6))
            0, 1: push_byte(CH_LPAREN);
            2:
            begin
                push_blanks($urandom_range(1, 3));
                push_byte(CH_LPAREN);
            end
            3:
            begin
                push_blanks($urandom_range(1, 2));
                push_byte(8'($urandom_range(0, 255)));
            end
            4:       push_byte(8'($urandom_range(0, 255)));
            5:       push_end(1'($urandom_range(0, 1)));
            default: ;
        endcase
    endfunction

    function automatic void push_string();
        push_byte(CH_QUOTE);
        if ($urandom_range(0, 3) == 0)
            push_marker(1);
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                push_byte(CH_BSLASH);
                push_byte(8'($urandom_range(0, 255)));
            end
            else
                push_byte(8'($urandom_range(8'h20, 8'h7e)));
        end
        push_byte(CH_QUOTE);
    endfunction

    function automatic void push_raw();
        logic [7:0] tag [$];
        logic       over;
        int         n;
        over = ($urandom_range(0, 9) == 0);
        n    = over ? DEF_RAW_DELIM_SLOTS : $urandom_range(0, 4);
        repeat (n) tag.push_back(name_byte(1'b0));
        push_byte(CH_UPPER_R);
        push_byte(CH_QUOTE);
        foreach (tag[i])
            push_byte(tag[i]);
        if (!over)
            push_byte(CH_LPAREN);
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(0, 2) == 0 && n > 0)
            begin
                // close that breaks off early
                push_byte(CH_RPAREN);
                for (int i = 0; i < $urandom_range(0, n - 1); i++)
                    push_byte(tag[i]);
            end
            else
                push_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 2) == 0)
            push_marker(1);
        push_byte(CH_RPAREN);
        foreach (tag[i])
            push_byte(tag[i]);
        if (!over)
            push_byte(CH_QUOTE);
    endfunction

    function automatic void load_random(input int target);
        int pick;
        while (source_q.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                push_export();
            else if (pick < 62)
                push_string();
            else if (pick < 74)
                push_raw();
            else if (pick < 82)
            begin
                push_blanks(1);
                push_marker(1, $urandom_range(1, 14));
                push_byte(8'($urandom_range(8'h21, 8'h7e)));
            end
            else if (pick < 97)
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
            else
                push_end(1'($urandom_range(0, 1)));
        end
    endfunction

    // ---------------------------------------------------------------- channels

    task automatic send_item(input item_t it);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= it.data_byte;
        end_of_input <= it.end_of_input;
        read_failed  <= it.read_failed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_stall <= !steady && !draining && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // no transaction on either channel for too long means the block hangs
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** export_marker_scanner_core: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int first_random;
        int n;
        load_directed();
        first_random = source_q.size();
        load_random(first_random + RANDOM_ITEMS);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        n = 0;
        while (source_q.size() > 0)
        begin
            steady <= (n >= first_random + 40 && n < first_random + 240);
            send_item(source_q.pop_front());
            n++;
        end
        in_valid <= 1'b0;
        draining <= 1'b1;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** export_marker_scanner_core: PASSED **");
        else
            $display("** export_marker_scanner_core: FAILED **");
        $finish;
    end

endmodule

// File: export_marker_scanner_core.f
rtl/ems_pkg.sv
rtl/ems_scan.sv
rtl/export_marker_scanner_core.sv
verif/export_marker_checker.sv
verif/tb_export_marker_scanner_core.sv
